>>> design/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants of the 3D vector normalizer
// Item layouts, datapath widths and pipeline depths.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int COMP_BITS   = 16;
  localparam int FRAC_BITS   = 14;
  localparam int UNIT_BITS   = FRAC_BITS + 2;
  localparam int MAG_BITS    = COMP_BITS + 1;
  localparam int LEN_BITS    = 32;
  localparam int QUO_BITS    = 32;
  localparam int ROOT_BITS   = QUO_BITS / 2;
  localparam int SREM_BITS   = ROOT_BITS + 4;
  localparam int DIV_STAGES  = QUO_BITS / 2;
  localparam int SQRT_STAGES = ROOT_BITS / 2;
  localparam int LANE_LAT    = DIV_STAGES + SQRT_STAGES + 1;
  localparam int TOTAL_LAT   = LANE_LAT + 4;
  localparam logic [UNIT_BITS-1:0] UNIT_ONE = UNIT_BITS'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] x_in;
    logic signed [COMP_BITS-1:0] y_in;
    logic signed [COMP_BITS-1:0] z_in;
  } in_t;

  typedef struct packed {
    logic signed [UNIT_BITS-1:0] x_unit;
    logic signed [UNIT_BITS-1:0] y_unit;
    logic signed [UNIT_BITS-1:0] z_unit;
    logic                        zero_length;
  } out_t;

endpackage

>>> design/vn_lane.sv
// ----------------------------------------------------------------------------
// vn_lane: one component of the normalizer
// Pipelined restoring division of the scaled square by the squared length,
// then a pipelined integer square root and the final rounding step.
// ----------------------------------------------------------------------------
module vn_lane (
  input  logic                            clk_i,
  input  logic [vn_pkg::LEN_BITS-1:0]     sq_i,
  input  logic [vn_pkg::LEN_BITS-1:0]     len_i,
  output logic [vn_pkg::UNIT_BITS-1:0]    mag_o
);

  localparam int LB = vn_pkg::LEN_BITS;
  localparam int QB = vn_pkg::QUO_BITS;
  localparam int RB = vn_pkg::ROOT_BITS;
  localparam int SB = vn_pkg::SREM_BITS;

  function automatic logic [LB:0] div_step(input logic [LB-1:0] rem,
                                           input logic bit_in,
                                           input logic [LB-1:0] den);
    logic [LB:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, den}) begin
      t = t - {1'b0, den};
      return {1'b1, t[LB-1:0]};
    end
    return {1'b0, t[LB-1:0]};
  endfunction

  function automatic logic [SB+RB-1:0] sqrt_step(input logic [SB-1:0] rem,
                                                 input logic [RB-1:0] root,
                                                 input logic [1:0] pair);
    logic [SB-1:0] t;
    logic [SB-1:0] trial;
    t = {rem[SB-3:0], pair};
    trial = SB'({root, 2'b01});
    if (t >= trial) begin
      return {t - trial, root[RB-2:0], 1'b1};
    end
    return {t, root[RB-2:0], 1'b0};
  endfunction

  logic [LB-1:0] rem_q [vn_pkg::DIV_STAGES];
  logic [QB-1:0] quo_q [vn_pkg::DIV_STAGES];
  logic [LB-1:0] den_q [vn_pkg::DIV_STAGES];

  for (genvar k = 0; k < vn_pkg::DIV_STAGES; k++) begin : g_div
    logic [LB-1:0] rem_in;
    logic [QB-1:0] quo_in;
    logic [LB-1:0] den_in;
    logic [1:0]    bits_in;
    logic [LB:0]   s0;
    logic [LB:0]   s1;
    if (k == 0) begin : g_first
      assign rem_in  = sq_i >> 2;
      assign quo_in  = '0;
      assign den_in  = len_i;
      assign bits_in = sq_i[1:0];
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign bits_in = 2'b00;
    end
    always_comb begin
      s0 = div_step(rem_in, bits_in[1], den_in);
      s1 = div_step(s0[LB-1:0], bits_in[0], den_in);
    end
    always_ff @(posedge clk_i) begin
      rem_q[k] <= s1[LB-1:0];
      quo_q[k] <= {quo_in[QB-3:0], s0[LB], s1[LB]};
      den_q[k] <= den_in;
    end
  end

  logic [SB-1:0] srem_q [vn_pkg::SQRT_STAGES];
  logic [RB-1:0] root_q [vn_pkg::SQRT_STAGES];
  logic [QB-1:0] rad_q  [vn_pkg::SQRT_STAGES];

  for (genvar j = 0; j < vn_pkg::SQRT_STAGES; j++) begin : g_sqrt
    logic [SB-1:0]    srem_in;
    logic [RB-1:0]    root_in;
    logic [QB-1:0]    rad_in;
    logic [SB+RB-1:0] t0;
    logic [SB+RB-1:0] t1;
    if (j == 0) begin : g_first
      assign srem_in = '0;
      assign root_in = '0;
      assign rad_in  = quo_q[vn_pkg::DIV_STAGES-1];
    end else begin : g_next
      assign srem_in = srem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
    end
    always_comb begin
      t0 = sqrt_step(srem_in, root_in, rad_in[QB-1:QB-2]);
      t1 = sqrt_step(t0[SB+RB-1:RB], t0[RB-1:0], rad_in[QB-3:QB-4]);
    end
    always_ff @(posedge clk_i) begin
      srem_q[j] <= t1[SB+RB-1:RB];
      root_q[j] <= t1[RB-1:0];
      rad_q[j]  <= rad_in << 4;
    end
  end

  logic [RB:0]                    half_d;
  logic [vn_pkg::UNIT_BITS-1:0]   mag_d;
  logic [vn_pkg::UNIT_BITS-1:0]   mag_q;

  always_comb begin
    half_d = ({1'b0, root_q[vn_pkg::SQRT_STAGES-1]} + (RB+1)'(1)) >> 1;
    if (half_d > (RB+1)'(vn_pkg::UNIT_ONE)) begin
      mag_d = vn_pkg::UNIT_ONE;
    end else begin
      mag_d = half_d[vn_pkg::UNIT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

  assign mag_o = mag_q;

endmodule

>>> design/vector3_normalizer.sv
// ----------------------------------------------------------------------------
// vector3_normalizer: scales a 3D integer vector to a Q2.14 unit vector
// Squared length, per-component division and square root, rounded result.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy_o stays low, the pipeline always moves.
// Depth is set by the 2-bit-per-stage divider and square root in each lane.
// Reset clears the valid bits of every stage; data registers are not reset.
module vector3_normalizer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  vn_pkg::in_t  in_i,
  output logic         valid_o,
  output vn_pkg::out_t res_o
);

  localparam int CB = vn_pkg::COMP_BITS;
  localparam int MB = vn_pkg::MAG_BITS;
  localparam int LB = vn_pkg::LEN_BITS;
  localparam int UB = vn_pkg::UNIT_BITS;
  localparam int LL = vn_pkg::LANE_LAT;

  logic [CB-1:0] comp_in [3];
  assign comp_in[0] = in_i.x_in;
  assign comp_in[1] = in_i.y_in;
  assign comp_in[2] = in_i.z_in;
  assign busy_o = 1'b0;

  logic          v1_q, v2_q, v3_q;
  logic [MB-1:0] mag1_q [3];
  logic [2:0]    neg1_q, neg2_q, neg3_q;
  logic [LB-1:0] sq2_q [3];
  logic [LB-1:0] sq3_q [3];
  logic [LB-1:0] len3_q;
  logic [2*MB-1:0] prod [3];

  for (genvar i = 0; i < 3; i++) begin : g_comp
    logic [MB-1:0] ext;
    assign ext  = {comp_in[i][CB-1], comp_in[i]};
    assign prod[i] = (2*MB)'(mag1_q[i]) * (2*MB)'(mag1_q[i]);
    always_ff @(posedge clk_i) begin
      mag1_q[i] <= comp_in[i][CB-1] ? (~ext + MB'(1)) : ext;
      neg1_q[i] <= comp_in[i][CB-1];
      sq2_q[i]  <= prod[i][LB-1:0];
      sq3_q[i]  <= sq2_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    neg2_q <= neg1_q;
    neg3_q <= neg2_q;
    len3_q <= sq2_q[0] + sq2_q[1] + sq2_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  logic [UB-1:0] lane_mag [3];
  for (genvar i = 0; i < 3; i++) begin : g_lane
    vn_lane u_lane (
      .clk_i (clk_i),
      .sq_i  (sq3_q[i]),
      .len_i (len3_q),
      .mag_o (lane_mag[i])
    );
  end

  logic [LL-1:0] vdl_q;
  logic [2:0]    ndl_q [LL];
  logic          zdl_q [LL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vdl_q <= '0;
    end else begin
      vdl_q <= {vdl_q[LL-2:0], v3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    ndl_q[0] <= neg3_q;
    zdl_q[0] <= (len3_q == '0);
    for (int k = 1; k < LL; k++) begin
      ndl_q[k] <= ndl_q[k-1];
      zdl_q[k] <= zdl_q[k-1];
    end
  end

  logic [UB-1:0] unit_d [3];
  for (genvar i = 0; i < 3; i++) begin : g_sign
    assign unit_d[i] = zdl_q[LL-1] ? '0 :
                       (ndl_q[LL-1][i] ? (~lane_mag[i] + UB'(1)) : lane_mag[i]);
  end

  logic         valid_q;
  vn_pkg::out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vdl_q[LL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.x_unit      <= unit_d[0];
    res_q.y_unit      <= unit_d[1];
    res_q.z_unit      <= unit_d[2];
    res_q.zero_length <= zdl_q[LL-1];
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.x_unit <= 16384 && res_o.x_unit >= -16384 &&
                 res_o.y_unit <= 16384 && res_o.y_unit >= -16384 &&
                 res_o.z_unit <= 16384 && res_o.z_unit >= -16384))
    else $error("unit component out of range");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.zero_length) |->
      (res_o.x_unit == 0 && res_o.y_unit == 0 && res_o.z_unit == 0))
    else $error("zero vector gave nonzero components");

  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !res_o.zero_length) |->
      (res_o.x_unit >= 9000 || res_o.x_unit <= -9000 ||
       res_o.y_unit >= 9000 || res_o.y_unit <= -9000 ||
       res_o.z_unit >= 9000 || res_o.z_unit <= -9000))
    else $error("nonzero vector gave a result far below unit length");

endmodule
